/* rtl/rcb_pkg.sv */
// Shared types and constants for the ring command buffer.
`default_nettype none

package rcb_pkg;

  // Fixed field widths.
  localparam int ACTION_W = 2;
  localparam int OFFSET_W = 12;
  localparam int DATA_W   = 8;
  localparam int AMOUNT_W = 12;
  localparam int SPACE_W  = 13;
  localparam int CFG_W    = 13;
  // Addend: offset, offset plus guard gap, or a rounded advance step.
  localparam int ADD_W    = 13;

  localparam int MIN_SIZE   = 16;
  localparam int RESET_SIZE = 4096;
  localparam int SPACE_MAX  = 8191;
  localparam int ROUND_ADD  = 3;

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_ADV_WR = 2'd2,
    ACT_ADV_RD = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOD,
    BK_APPLY,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    act_e                action;
    logic                use_wp;
    logic [ADD_W-1:0]    addend;
    logic [DATA_W-1:0]   data;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

`default_nettype wire

/* rtl/rcb_front.sv */
// Front end: input handshake and decoding of an item into a command.
`default_nettype none

module rcb_front #(
  parameter int GUARD_GAP = 4
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rcb_pkg::ACTION_W-1:0]  action,
  input  wire logic [rcb_pkg::OFFSET_W-1:0]  byte_offset,
  input  wire logic [rcb_pkg::DATA_W-1:0]    write_byte,
  input  wire logic [rcb_pkg::AMOUNT_W-1:0]  amount,
  input  wire rcb_pkg::q_status_t            q_st,
  output logic                               push,
  output rcb_pkg::cmd_t                      push_cmd
);

  rcb_pkg::act_e               act;
  logic [rcb_pkg::ADD_W-1:0]   rounded;

  assign in_ready = !q_st.full;
  assign push     = in_valid && in_ready;
  assign act      = rcb_pkg::act_e'(action);

  // Advance steps round up to a multiple of four.
  assign rounded = (rcb_pkg::ADD_W'(amount) + rcb_pkg::ADD_W'(rcb_pkg::ROUND_ADD))
                   & ~rcb_pkg::ADD_W'(rcb_pkg::ROUND_ADD);

  // Pick the base pointer and the distance added to it.
  always_comb begin
    push_cmd.action = act;
    push_cmd.data   = write_byte;
    push_cmd.amount = amount;
    unique case (act)
      rcb_pkg::ACT_WRITE: begin
        push_cmd.use_wp = 1'b1;
        push_cmd.addend = rcb_pkg::ADD_W'(byte_offset);
      end
      rcb_pkg::ACT_READ: begin
        push_cmd.use_wp = 1'b0;
        push_cmd.addend = rcb_pkg::ADD_W'(byte_offset) + rcb_pkg::ADD_W'(GUARD_GAP);
      end
      rcb_pkg::ACT_ADV_WR: begin
        push_cmd.use_wp = 1'b1;
        push_cmd.addend = rounded;
      end
      default: begin
        push_cmd.use_wp = 1'b0;
        push_cmd.addend = rounded;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rcb_queue.sv */
// Two-entry command queue between the front end and the back end.
`default_nettype none

module rcb_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire rcb_pkg::cmd_t      push_cmd,
  input  wire logic               pop,
  output rcb_pkg::cmd_t           head,
  output rcb_pkg::q_status_t      st
);

  rcb_pkg::cmd_t                entries [rcb_pkg::Q_DEPTH];
  logic [rcb_pkg::Q_IDX_W-1:0]  wr_idx;
  logic [rcb_pkg::Q_IDX_W-1:0]  rd_idx;
  logic [rcb_pkg::Q_CNT_W-1:0]  count;
  logic                         do_push;
  logic                         do_pop;

  assign st.empty = (count == '0);
  assign st.full  = (count == rcb_pkg::Q_CNT_W'(rcb_pkg::Q_DEPTH));
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign head     = entries[rd_idx];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_idx <= wr_idx + 1'b1;
      if (do_pop)  rd_idx <= rd_idx + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_idx] <= push_cmd;
  end

endmodule

`default_nettype wire

/* rtl/rcb_mod.sv */
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit a cycle.
`default_nettype none

module rcb_mod #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = 13,
  localparam int CntW      = $clog2(DIVIDEND_W + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [DIVIDEND_W-1:0]  dividend,
  input  wire logic [DIVISOR_W-1:0]   divisor,
  output rcb_pkg::mod_status_t        st,
  output logic [DIVISOR_W-1:0]        rem
);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  div;
  logic [CntW-1:0]       cnt;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_next;

  // Bring in the next dividend bit and subtract the divisor if it fits.
  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign diff     = trial - {1'b0, div};
  assign rem_next = (trial >= {1'b0, div}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  assign st.busy = busy;
  assign st.done = done;

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rcb_back.sv */
// Back end: pointers, byte store, command sequencing and the result register.
`default_nettype none

module rcb_back #(
  parameter int DEPTH     = 4096,
  parameter int GUARD_GAP = 4,
  localparam int PtrW     = $clog2(DEPTH),
  localparam int SzW      = $clog2(DEPTH + 1),
  localparam int SumW     = ((PtrW > rcb_pkg::ADD_W) ? PtrW : rcb_pkg::ADD_W) + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rcb_pkg::CFG_W-1:0]     buffer_size,
  input  wire rcb_pkg::cmd_t                 q_head,
  input  wire rcb_pkg::q_status_t            q_st,
  output logic                               q_pop,
  output logic                               mod_start,
  output logic [SumW-1:0]                    mod_dividend,
  output logic [SzW-1:0]                     mod_divisor,
  input  wire rcb_pkg::mod_status_t          mod_st,
  input  wire logic [SzW-1:0]                mod_rem,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rcb_pkg::DATA_W-1:0]         read_byte,
  output logic [rcb_pkg::SPACE_W-1:0]        read_space,
  output logic [rcb_pkg::SPACE_W-1:0]        write_space,
  output logic                               read_fits,
  output logic                               write_fits
);

  // Wide enough for sizes, the guard gap and the space limit.
  localparam int ExtW      = (SzW > 14) ? SzW : 14;
  localparam int ResetSize = (rcb_pkg::RESET_SIZE < DEPTH) ? rcb_pkg::RESET_SIZE : DEPTH;
  localparam int ResetWp   = GUARD_GAP % ResetSize;
  localparam int GapSteps  = GUARD_GAP / rcb_pkg::MIN_SIZE;

  rcb_pkg::back_state_e         state;
  rcb_pkg::back_state_e         state_next;
  rcb_pkg::cmd_t                cur;
  logic [SzW-1:0]               size;
  logic [PtrW-1:0]              rp;
  logic [PtrW-1:0]              wp;
  logic [rcb_pkg::DATA_W-1:0]   store [DEPTH];
  logic [rcb_pkg::DATA_W-1:0]   rdata;
  logic [PtrW-1:0]              addr;
  logic                         apply;
  logic                         load_out;
  logic                         cfg_write;
  logic [ExtW-1:0]              cfg_ext;
  logic [SzW-1:0]               size_next;
  logic [ExtW-1:0]              gap_mod;
  logic [SzW-1:0]               dist_rd;
  logic [SzW-1:0]               dist_wr;
  logic [rcb_pkg::SPACE_W-1:0]  rs;
  logic [rcb_pkg::SPACE_W-1:0]  ws;

  // Distance minus the guard gap, floored at zero and capped at the space limit.
  function automatic logic [rcb_pkg::SPACE_W-1:0] space_of(input logic [SzW-1:0] span);
    logic [ExtW-1:0] d;
    logic [ExtW-1:0] s;
    d = ExtW'(span);
    s = (d > ExtW'(GUARD_GAP)) ? d - ExtW'(GUARD_GAP) : '0;
    if (s > ExtW'(rcb_pkg::SPACE_MAX)) begin
      return rcb_pkg::SPACE_W'(rcb_pkg::SPACE_MAX);
    end
    return s[rcb_pkg::SPACE_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign addr      = mod_rem[PtrW-1:0];

  // Clamp the written size to the supported range.
  always_comb begin
    cfg_ext = ExtW'(buffer_size);
    if (cfg_ext < ExtW'(rcb_pkg::MIN_SIZE)) begin
      size_next = SzW'(rcb_pkg::MIN_SIZE);
    end else if (cfg_ext > ExtW'(DEPTH)) begin
      size_next = SzW'(DEPTH);
    end else begin
      size_next = cfg_ext[SzW-1:0];
    end
  end

  // Guard gap modulo the new size; the gap spans only a few minimum sizes.
  always_comb begin
    gap_mod = ExtW'(GUARD_GAP);
    for (int i = 0; i < GapSteps; i++) begin
      if (gap_mod >= ExtW'(size_next)) gap_mod = gap_mod - ExtW'(size_next);
    end
  end

  // Dividend for the remainder unit: base pointer plus the command's addend.
  assign mod_dividend = (q_head.use_wp ? SumW'(wp) : SumW'(rp)) + SumW'(q_head.addend);
  assign mod_divisor  = size;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rcb_pkg::BK_IDLE:   if (!q_st.empty) state_next = rcb_pkg::BK_MOD;
      rcb_pkg::BK_MOD:    if (mod_st.done) state_next = rcb_pkg::BK_APPLY;
      rcb_pkg::BK_APPLY:  state_next = rcb_pkg::BK_FINISH;
      rcb_pkg::BK_FINISH: if (!out_valid || out_ready) state_next = rcb_pkg::BK_IDLE;
      default:            state_next = rcb_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop     = 1'b0;
    mod_start = 1'b0;
    apply     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      rcb_pkg::BK_IDLE: begin
        q_pop     = !q_st.empty;
        mod_start = !q_st.empty;
      end
      rcb_pkg::BK_MOD:    ;
      rcb_pkg::BK_APPLY:  apply = 1'b1;
      rcb_pkg::BK_FINISH: load_out = !out_valid || out_ready;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcb_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Current command.
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  // Size and pointers; a size write puts rp at zero and wp at the guard gap modulo the new size.
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SzW'(ResetSize);
      rp   <= '0;
      wp   <= PtrW'(ResetWp);
    end else if (cfg_write) begin
      size <= size_next;
      rp   <= '0;
      wp   <= gap_mod[PtrW-1:0];
    end else if (apply) begin
      if (cur.action == rcb_pkg::ACT_ADV_WR) wp <= addr;
      if (cur.action == rcb_pkg::ACT_ADV_RD) rp <= addr;
    end
  end

  // Byte store with registered read.
  always_ff @(posedge clk) begin
    if (apply && cur.action == rcb_pkg::ACT_WRITE) store[addr] <= cur.data;
    if (apply && cur.action == rcb_pkg::ACT_READ)  rdata <= store[addr];
  end

  // Ring distances and spaces from the updated pointers.
  assign dist_rd = (wp >= rp) ? SzW'(wp) - SzW'(rp) : SzW'(wp) + size - SzW'(rp);
  assign dist_wr = (rp >= wp) ? SzW'(rp) - SzW'(wp) : SzW'(rp) + size - SzW'(wp);
  assign rs      = space_of(dist_rd);
  assign ws      = space_of(dist_wr);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_byte   <= (cur.action == rcb_pkg::ACT_READ) ? rdata : '0;
      read_space  <= rs;
      write_space <= ws;
      read_fits   <= (rs >= rcb_pkg::SPACE_W'(cur.amount));
      write_fits  <= (ws >= rcb_pkg::SPACE_W'(cur.amount));
    end
  end

endmodule

`default_nettype wire

/* rtl/ring_command_buffer.sv */
// Top level of the ring command buffer: front end, command queue, back end.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_valid / cfg_ready   buffer_size
//   in       in         in_valid / in_ready     action, byte_offset, write_byte, amount
//   out      out        out_valid / out_ready   read_byte, read_space, write_space,
//                                               read_fits, write_fits
//
// In the back end each item waits on the bit-serial remainder unit, which
// reduces every address and advanced pointer modulo the ring size. Items are
// worked one at a time.
// The two-entry queue keeps taking input while the back end is busy or a result
// waits in the output register; in_ready drops only when the queue is full.
// Reset is synchronous and restores size 4096 (or DEPTH if smaller) and both
// pointers; the byte store is not cleared. cfg_ready is always high.
`default_nettype none

module ring_command_buffer #(
  parameter int DEPTH     = 4096,
  parameter int GUARD_GAP = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rcb_pkg::CFG_W-1:0]     buffer_size,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rcb_pkg::ACTION_W-1:0]  action,
  input  wire logic [rcb_pkg::OFFSET_W-1:0]  byte_offset,
  input  wire logic [rcb_pkg::DATA_W-1:0]    write_byte,
  input  wire logic [rcb_pkg::AMOUNT_W-1:0]  amount,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rcb_pkg::DATA_W-1:0]         read_byte,
  output logic [rcb_pkg::SPACE_W-1:0]        read_space,
  output logic [rcb_pkg::SPACE_W-1:0]        write_space,
  output logic                               read_fits,
  output logic                               write_fits
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int SzW  = $clog2(DEPTH + 1);
  localparam int SumW = ((PtrW > rcb_pkg::ADD_W) ? PtrW : rcb_pkg::ADD_W) + 1;

  rcb_pkg::q_status_t    q_st;
  rcb_pkg::cmd_t         push_cmd;
  rcb_pkg::cmd_t         q_head;
  rcb_pkg::mod_status_t  mod_st;
  logic                  push;
  logic                  q_pop;
  logic                  mod_start;
  logic [SumW-1:0]       mod_dividend;
  logic [SzW-1:0]        mod_divisor;
  logic [SzW-1:0]        mod_rem;

  rcb_front #(
    .GUARD_GAP (GUARD_GAP)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .byte_offset (byte_offset),
    .write_byte  (write_byte),
    .amount      (amount),
    .q_st        (q_st),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  rcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .st       (q_st)
  );

  rcb_mod #(
    .DIVIDEND_W (SumW),
    .DIVISOR_W  (SzW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .st       (mod_st),
    .rem      (mod_rem)
  );

  rcb_back #(
    .DEPTH     (DEPTH),
    .GUARD_GAP (GUARD_GAP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .buffer_size  (buffer_size),
    .q_head       (q_head),
    .q_st         (q_st),
    .q_pop        (q_pop),
    .mod_start    (mod_start),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_st       (mod_st),
    .mod_rem      (mod_rem),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .read_space   (read_space),
    .write_space  (write_space),
    .read_fits    (read_fits),
    .write_fits   (write_fits)
  );

  // The queue cannot be empty and full at once.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_st.empty && q_st.full))
    else $error("command queue reports empty and full together");

  // The back end only takes a command that is present.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_st.empty)
    else $error("command taken from an empty queue");

  // A new remainder operation never starts over a running one.
  a_mod_idle_start: assert property (@(posedge clk) disable iff (rst)
    mod_start |-> (!mod_st.busy && !mod_st.done))
    else $error("remainder unit restarted while busy");

  // Completion is a single-cycle pulse.
  a_mod_done_pulse: assert property (@(posedge clk) disable iff (rst)
    mod_st.done |=> !mod_st.done)
    else $error("remainder completion held for more than one cycle");

endmodule

`default_nettype wire
